FILE: rtl/srs_pkg.sv
`default_nettype none

package srs_pkg;

  // Sample width is fixed by the payload format
  localparam int SAMPLE_WIDTH = 16;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } srs_in_t;

  typedef struct packed {
    logic [31:0] range_sum;
    logic        too_long;
  } srs_out_t;

  // Commands to one monotonic stack
  typedef struct packed {
    logic load_top;  // read the entry at depth-1
    logic pop;       // drop the top, read the entry below it
    logic push;      // write a new top at depth
    logic clear;     // empty the stack
  } srs_stk_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CMP  = 5'b00010,
    S_ACC  = 5'b00100,
    S_TOT  = 5'b01000,
    S_DONE = 5'b10000
  } srs_state_e;

endpackage

`default_nettype wire

FILE: rtl/srs_stack.sv
`default_nettype none

module srs_stack import srs_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire srs_stk_ctrl_t                     ctrl_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    wr_value_i,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]      wr_count_i,
  output logic signed [SAMPLE_WIDTH-1:0]         rd_value_o,
  output logic [$clog2(MAX_LEN+1)-1:0]           rd_count_o,
  output logic [$clog2(MAX_LEN+1)-1:0]           depth_o
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int EW = SAMPLE_WIDTH + CW;

  logic [EW-1:0] mem [MAX_LEN];
  logic [EW-1:0] rd_q;
  logic [CW-1:0] depth_q, depth_d;
  logic [CW-1:0] rd_ptr;
  logic          rd_en;
  logic          wr_en;

  // Top read goes to depth-1, read after a pop to depth-2
  always_comb begin
    rd_ptr = ctrl_i.load_top ? (depth_q - CW'(1)) : (depth_q - CW'(2));
    rd_en  = (ctrl_i.load_top && (depth_q != '0)) ||
             (ctrl_i.pop && (depth_q > CW'(1)));
    wr_en  = ctrl_i.push && (depth_q != CW'(MAX_LEN));
  end

  // Track the stack depth
  always_comb begin
    depth_d = depth_q;
    if (ctrl_i.clear) begin
      depth_d = '0;
    end else if (ctrl_i.pop) begin
      depth_d = depth_q - CW'(1);
    end else if (wr_en) begin
      depth_d = depth_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[depth_q[AW-1:0]] <= {wr_value_i, wr_count_i};
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_ptr[AW-1:0]];
    end
  end

  assign rd_value_o = $signed(rd_q[EW-1:CW]);
  assign rd_count_o = rd_q[CW-1:0];
  assign depth_o    = depth_q;

endmodule

`default_nettype wire

FILE: rtl/subarray_range_sum.sv
// Sequence: a sample is taken in S_IDLE and compared in S_CMP with the max, then the min
//   stack, each pop using the shared compare/multiply path. Its last product lands in
//   S_ACC and the total is updated in S_TOT, then S_IDLE takes the next sample or, after
//   the final one, S_DONE loads the result register once the output is free; it is held
//   until taken. Every sample is pushed and popped at most once per stack.
// Reset: asynchronous, active low; clears control, counters and sums. Stack memories are
//   not cleared: only entries below the stack depth are ever read.
`default_nettype none

module subarray_range_sum import srs_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire srs_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output srs_out_t      out_data_o
);

  localparam int CW   = $clog2(MAX_LEN + 1);
  localparam int SW   = SAMPLE_WIDTH;
  localparam int PW   = SW + CW + 1;
  localparam int SUMW = PW;

  srs_state_e state_q, state_d;

  logic signed [SW-1:0]   x_q, x_d;
  logic                   last_q, last_d;
  logic                   sel_q, sel_d;      // 0: max stack, 1: min stack
  logic [CW-1:0]          run_q, run_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   too_long_q, too_long_d;
  logic signed [SUMW-1:0] sum_max_q, sum_max_d;
  logic signed [SUMW-1:0] sum_min_q, sum_min_d;
  logic [31:0]            total_q, total_d;
  logic                   acc_pend_q, acc_pend_d;
  logic                   acc_neg_q, acc_neg_d;
  logic                   acc_sel_q, acc_sel_d;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic                   out_valid_q, out_valid_d;
  srs_out_t               out_q, out_d;

  srs_stk_ctrl_t          max_ctrl, min_ctrl;
  logic signed [SW-1:0]   max_rd_value, min_rd_value;
  logic [CW-1:0]          max_rd_count, min_rd_count;
  logic [CW-1:0]          max_depth, min_depth;

  logic signed [SW-1:0]   top_value;
  logic [CW-1:0]          top_count;
  logic [CW-1:0]          top_depth;
  logic                   do_pop;
  logic signed [SW-1:0]   mul_a;
  logic signed [CW:0]     mul_b;
  logic signed [SUMW:0]   diff;
  logic [32:0]            total_sum;
  logic                   in_req;
  logic                   out_free;

  srs_stack #(.MAX_LEN(MAX_LEN)) u_max_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (max_ctrl),
    .wr_value_i (x_q),
    .wr_count_i (run_q),
    .rd_value_o (max_rd_value),
    .rd_count_o (max_rd_count),
    .depth_o    (max_depth)
  );

  srs_stack #(.MAX_LEN(MAX_LEN)) u_min_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (min_ctrl),
    .wr_value_i (x_q),
    .wr_count_i (run_q),
    .rd_value_o (min_rd_value),
    .rd_count_o (min_rd_count),
    .depth_o    (min_depth)
  );

  // Select the stack under work and decide whether its top goes
  always_comb begin
    top_value = sel_q ? min_rd_value : max_rd_value;
    top_count = sel_q ? min_rd_count : max_rd_count;
    top_depth = sel_q ? min_depth : max_depth;
    if (top_depth == '0) begin
      do_pop = 1'b0;
    end else if (sel_q) begin
      do_pop = (top_value >= x_q);
    end else begin
      do_pop = (top_value <= x_q);
    end
    mul_a  = do_pop ? top_value : x_q;
    mul_b  = $signed({1'b0, (do_pop ? top_count : run_q)});
    prod_d = PW'(mul_a) * PW'(mul_b);
  end

  // Saturating total update
  always_comb begin
    diff      = {sum_max_q[SUMW-1], sum_max_q} - {sum_min_q[SUMW-1], sum_min_q};
    total_sum = {1'b0, total_q} + 33'($unsigned(diff));
  end

  assign in_req   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    last_d      = last_q;
    sel_d       = sel_q;
    run_d       = run_q;
    count_d     = count_q;
    too_long_d  = too_long_q;
    total_d     = total_q;
    acc_pend_d  = 1'b0;
    acc_neg_d   = acc_neg_q;
    acc_sel_d   = acc_sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    max_ctrl    = '0;
    min_ctrl    = '0;
    sum_max_d   = sum_max_q;
    sum_min_d   = sum_min_q;

    // Land the pending product in its sum
    if (acc_pend_q) begin
      if (acc_sel_q) begin
        sum_min_d = acc_neg_q ? (sum_min_q - prod_q) : (sum_min_q + prod_q);
      end else begin
        sum_max_d = acc_neg_q ? (sum_max_q - prod_q) : (sum_max_q + prod_q);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_req) begin
          if (count_q == CW'(MAX_LEN)) begin
            too_long_d = 1'b1;
            if (in_data_i.last) begin
              state_d = S_DONE;
            end
          end else begin
            x_d               = in_data_i.sample;
            last_d            = in_data_i.last;
            count_d           = count_q + CW'(1);
            sel_d             = 1'b0;
            run_d             = CW'(1);
            max_ctrl.load_top = 1'b1;
            state_d           = S_CMP;
          end
        end
      end
      S_CMP: begin
        acc_pend_d = 1'b1;
        acc_sel_d  = sel_q;
        acc_neg_d  = do_pop;
        if (do_pop) begin
          // Merge the top run into the new sample's run
          run_d = run_q + top_count;
          if (sel_q) begin
            min_ctrl.pop = 1'b1;
          end else begin
            max_ctrl.pop = 1'b1;
          end
        end else if (sel_q) begin
          min_ctrl.push = 1'b1;
          state_d       = S_ACC;
        end else begin
          // Push on the max stack, move over to the min stack
          max_ctrl.push     = 1'b1;
          min_ctrl.load_top = 1'b1;
          sel_d             = 1'b1;
          run_d             = CW'(1);
        end
      end
      S_ACC: begin
        state_d = S_TOT;
      end
      S_TOT: begin
        total_d = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
        state_d = last_q ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.range_sum = total_q;
          out_d.too_long  = too_long_q;
          total_d         = '0;
          count_d         = '0;
          too_long_d      = 1'b0;
          sum_max_d       = '0;
          sum_min_d       = '0;
          max_ctrl.clear  = 1'b1;
          min_ctrl.clear  = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      count_q     <= '0;
      too_long_q  <= 1'b0;
      sum_max_q   <= '0;
      sum_min_q   <= '0;
      total_q     <= '0;
      acc_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      count_q     <= count_d;
      too_long_q  <= too_long_d;
      sum_max_q   <= sum_max_d;
      sum_min_q   <= sum_min_d;
      total_q     <= total_d;
      acc_pend_q  <= acc_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    last_q    <= last_d;
    run_q     <= run_d;
    acc_neg_q <= acc_neg_d;
    acc_sel_q <= acc_sel_d;
    prod_q    <= prod_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A stack never holds more entries than samples taken
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (max_depth <= count_q) && (min_depth <= count_q))
    else $error("stack depth exceeds sample count");

  // All products have landed before the total is updated
  a_acc_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOT) |-> !acc_pend_q)
    else $error("pending product at total update");

  // A waiting result is never overwritten
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE))
    else $error("result loaded while output busy");

  // The merged run never exceeds the samples taken
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (run_q <= count_q))
    else $error("run count exceeds sample count");

endmodule

`default_nettype wire
